// ===== design/rqd_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rqd_pkg: shared types, constants and level functions
// Register map, queue entry layout and the constant-divisor quantizers
// used by the RGB332 checker-dither converter.
// ----------------------------------------------------------------------------
package rqd_pkg;

  // column counter width and queue depth defaults
  localparam int WIDTH_BITS  = 16;
  localparam int QUEUE_DEPTH = 2;

  // configuration port
  localparam int PADDR_W   = 4;
  localparam int PDATA_W   = 32;
  localparam int REG_IDX_W = 2;
  localparam int IMG_W     = 16;

  localparam logic [REG_IDX_W-1:0] REG_DITHER_ENABLE = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_ALPHA_PRESENT = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_IMAGE_WIDTH   = 2'd2;

  localparam logic [IMG_W-1:0] IMAGE_WIDTH_RESET = 16'd320;

  localparam logic [7:0] KEY_TRANSPARENT = 8'd170;
  localparam logic [7:0] ALPHA_OPAQUE    = 8'd255;

  // 36.428 held as 36428/1000, its half as 18214/1000
  localparam int RG_SCALE = 1000;
  localparam int RG_STEP  = 36428;
  localparam int RG_HALF  = 18214;
  localparam int B_STEP   = 85;
  localparam int B_SCALE  = 2;
  localparam int RG_MAX   = 7;
  localparam int B_MAX    = 3;

  // highest quotient the ceiling can reach for an 8-bit channel
  localparam int RG_QMAX = (255 * RG_SCALE + RG_HALF - 1) / RG_HALF;
  localparam int B_QMAX  = (255 * B_SCALE + B_STEP - 1) / B_STEP;

  typedef struct packed {
    logic             dither_enable;
    logic             alpha_present;
    logic [IMG_W-1:0] image_width;
  } cfg_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       transparent;
    logic       same_parity;
  } entry_t;

  // round(c / 36.428): count the step boundaries at or below the value
  function automatic logic [2:0] plain_rg(logic [7:0] c);
    int num;
    int lvl;
    num = int'(c) * RG_SCALE + RG_HALF;
    lvl = 0;
    for (int k = 1; k <= RG_MAX; k++) begin
      if (num >= RG_STEP * k) lvl++;
    end
    return 3'(lvl);
  endfunction

  function automatic logic [1:0] plain_b(logic [7:0] c);
    int lvl;
    lvl = 0;
    for (int k = 1; k <= B_MAX; k++) begin
      if (int'(c) >= B_STEP * k) lvl++;
    end
    return 2'(lvl);
  endfunction

  // floor or ceil of c*1000/18214, halved and clamped
  function automatic logic [2:0] dith_rg(logic [7:0] c, logic take_floor);
    int num;
    int q;
    num = int'(c) * RG_SCALE;
    q = 0;
    for (int k = 1; k <= RG_QMAX; k++) begin
      if (take_floor ? (num >= RG_HALF * k) : (num > RG_HALF * (k - 1))) q++;
    end
    q = q >> 1;
    if (q > RG_MAX) q = RG_MAX;
    return 3'(q);
  endfunction

  // floor or ceil of c*2/85, halved and clamped
  function automatic logic [1:0] dith_b(logic [7:0] c, logic take_floor);
    int num;
    int q;
    num = int'(c) * B_SCALE;
    q = 0;
    for (int k = 1; k <= B_QMAX; k++) begin
      if (take_floor ? (num >= B_STEP * k) : (num > B_STEP * (k - 1))) q++;
    end
    q = q >> 1;
    if (q > B_MAX) q = B_MAX;
    return 2'(q);
  endfunction

endpackage
`default_nettype wire

// ===== design/rqd_pixel_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rqd_pixel_if: RGBA pixel stream
// Valid/ready channel carrying one source pixel and its frame marker.
// ----------------------------------------------------------------------------
interface rqd_pixel_if;
  logic       valid;
  logic       ready;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;
  logic [7:0] alpha;
  logic       frame_start;

  modport source(output valid, red, green, blue, alpha, frame_start, input ready);
  modport sink(input valid, red, green, blue, alpha, frame_start, output ready);
endinterface
`default_nettype wire

// ===== design/rqd_byte_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rqd_byte_if: RGB332 byte stream
// Valid/ready channel carrying one packed output pixel.
// ----------------------------------------------------------------------------
interface rqd_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] packed_pixel;

  modport source(output valid, packed_pixel, input ready);
  modport sink(input valid, packed_pixel, output ready);
endinterface
`default_nettype wire

// ===== design/rgb332_quantize_checker_dither.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rgb332_quantize_checker_dither: RGBA to RGB332 converter
// Quantizes a raster pixel stream to RGB332 with optional checkerboard dither.
// ----------------------------------------------------------------------------
// Takes one RGBA pixel per clock and returns one RGB332 byte per pixel, in
// order, at a sustained rate of one per clock unless the output stalls. An
// accepted pixel is classified (position, parity, transparency) and queued;
// its byte goes from the queue slot to the output register. The two-entry
// queue and the output register let intake keep going while a result waits.
// The quantizer is combinational, built from constant-threshold compares.
// Registers sit at byte addresses 0 (dither_enable), 4 (alpha_present) and 8
// (image_width). Users must see they are written only while the stream is
// idle; the block does not enforce it. No clearing pass follows reset.
// ----------------------------------------------------------------------------
module rgb332_quantize_checker_dither #(
  parameter int WIDTH_BITS  = rqd_pkg::WIDTH_BITS,
  parameter int QUEUE_DEPTH = rqd_pkg::QUEUE_DEPTH
) (
  input  wire                          clk,
  input  wire                          rst,
  input  wire                          psel,
  input  wire                          penable,
  input  wire                          pwrite,
  input  wire  [rqd_pkg::PADDR_W-1:0]  paddr,
  input  wire  [rqd_pkg::PDATA_W-1:0]  pwdata,
  output logic [rqd_pkg::PDATA_W-1:0]  prdata,
  output logic                         pready,
  rqd_pixel_if.sink                    pixel_stream,
  rqd_byte_if.source                   byte_stream
);

  rqd_pkg::cfg_t   cfg;
  rqd_pkg::entry_t push_entry;
  rqd_pkg::entry_t head;
  logic            push;
  logic            can_push;
  logic            pop;
  logic            head_valid;

  rqd_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  rqd_front #(.WIDTH_BITS(WIDTH_BITS)) u_front (
    .clk          (clk),
    .rst          (rst),
    .pixel_stream (pixel_stream),
    .cfg          (cfg),
    .can_push     (can_push),
    .push         (push),
    .entry        (push_entry)
  );

  rqd_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .can_push   (can_push),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head)
  );

  rqd_back u_back (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .head_valid  (head_valid),
    .head        (head),
    .pop         (pop),
    .byte_stream (byte_stream)
  );

endmodule
`default_nettype wire

// ===== design/rqd_regs.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rqd_regs: configuration registers
// APB-style register file for dither mode, alpha handling and image width.
// ----------------------------------------------------------------------------
module rqd_regs (
  input  wire                          clk,
  input  wire                          rst,
  input  wire                          psel,
  input  wire                          penable,
  input  wire                          pwrite,
  input  wire  [rqd_pkg::PADDR_W-1:0]  paddr,
  input  wire  [rqd_pkg::PDATA_W-1:0]  pwdata,
  output logic [rqd_pkg::PDATA_W-1:0]  prdata,
  output logic                         pready,
  output rqd_pkg::cfg_t                cfg
);

  logic [rqd_pkg::REG_IDX_W-1:0] index;
  logic                          wr_en;

  assign index  = paddr[rqd_pkg::REG_IDX_W+1:2];
  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.dither_enable <= 1'b0;
      cfg.alpha_present <= 1'b0;
      cfg.image_width   <= rqd_pkg::IMAGE_WIDTH_RESET;
    end else if (wr_en) begin
      case (index)
        rqd_pkg::REG_DITHER_ENABLE: cfg.dither_enable <= pwdata[0];
        rqd_pkg::REG_ALPHA_PRESENT: cfg.alpha_present <= pwdata[0];
        rqd_pkg::REG_IMAGE_WIDTH:   cfg.image_width   <= pwdata[rqd_pkg::IMG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (index)
      rqd_pkg::REG_DITHER_ENABLE:
        prdata = {{(rqd_pkg::PDATA_W-1){1'b0}}, cfg.dither_enable};
      rqd_pkg::REG_ALPHA_PRESENT:
        prdata = {{(rqd_pkg::PDATA_W-1){1'b0}}, cfg.alpha_present};
      rqd_pkg::REG_IMAGE_WIDTH:
        prdata = {{(rqd_pkg::PDATA_W-rqd_pkg::IMG_W){1'b0}}, cfg.image_width};
      default: prdata = '0;
    endcase
  end

endmodule
`default_nettype wire

// ===== design/rqd_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rqd_front: pixel intake and classification
// Accepts pixels, tracks column and row parity, flags transparent pixels
// and the checkerboard cell, and pushes the result into the queue.
// ----------------------------------------------------------------------------
module rqd_front #(
  parameter int WIDTH_BITS = rqd_pkg::WIDTH_BITS
) (
  input  wire              clk,
  input  wire              rst,
  rqd_pixel_if.sink        pixel_stream,
  input  rqd_pkg::cfg_t    cfg,
  input  wire              can_push,
  output logic             push,
  output rqd_pkg::entry_t  entry
);

  localparam int CMP_W = rqd_pkg::IMG_W + 1;

  logic [WIDTH_BITS-1:0] column;
  logic                  row_odd;
  logic [WIDTH_BITS-1:0] col_cur;
  logic                  row_cur;
  logic [CMP_W-1:0]      col_plus;
  logic                  wrap;

  assign pixel_stream.ready = can_push;
  assign push = pixel_stream.valid && can_push;

  // frame start puts this pixel at the origin
  assign col_cur = pixel_stream.frame_start ? '0 : column;
  assign row_cur = pixel_stream.frame_start ? 1'b0 : row_odd;

  assign col_plus = {{(CMP_W-WIDTH_BITS){1'b0}}, col_cur} + CMP_W'(1);
  assign wrap = (col_cur == '1) || (col_plus >= {1'b0, cfg.image_width});

  always_comb begin
    entry.red         = pixel_stream.red;
    entry.green       = pixel_stream.green;
    entry.blue        = pixel_stream.blue;
    entry.transparent = cfg.alpha_present && (pixel_stream.alpha != rqd_pkg::ALPHA_OPAQUE);
    entry.same_parity = (col_cur[0] == row_cur);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column  <= '0;
      row_odd <= 1'b0;
    end else if (push) begin
      if (wrap) begin
        column  <= '0;
        row_odd <= ~row_cur;
      end else begin
        column  <= col_cur + WIDTH_BITS'(1);
        row_odd <= row_cur;
      end
    end
  end

endmodule
`default_nettype wire

// ===== design/rqd_queue.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rqd_queue: classified pixel queue
// Small register FIFO that decouples pixel intake from quantization.
// ----------------------------------------------------------------------------
module rqd_queue #(
  parameter int DEPTH = rqd_pkg::QUEUE_DEPTH
) (
  input  wire              clk,
  input  wire              rst,
  input  wire              push,
  input  rqd_pkg::entry_t  push_entry,
  output logic             can_push,
  input  wire              pop,
  output logic             head_valid,
  output rqd_pkg::entry_t  head
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  rqd_pkg::entry_t  slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign head_valid = (count != '0);
  assign head       = slots[rd_ptr];
  // a pop in the same cycle frees the slot being written
  assign can_push   = (count != CNT_W'(DEPTH)) || pop;

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_entry;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      if (pop)  rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      if (push && !pop)      count <= count + CNT_W'(1);
      else if (pop && !push) count <= count - CNT_W'(1);
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH)) else $error("queue count above depth");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    pop |-> head_valid) else $error("pop from empty queue");

  a_count_up: assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |=> count == $past(count) + CNT_W'(1))
    else $error("queue count missed a push");

  a_ptr_gap: assert property (@(posedge clk) disable iff (rst)
    (count == '0) |-> (wr_ptr == rd_ptr)) else $error("empty queue with pointer gap");

endmodule
`default_nettype wire

// ===== design/rqd_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rqd_back: quantizer and output register
// Turns a queued pixel into an RGB332 byte and holds it until taken.
// ----------------------------------------------------------------------------
module rqd_back (
  input  wire              clk,
  input  wire              rst,
  input  rqd_pkg::cfg_t    cfg,
  input  wire              head_valid,
  input  rqd_pkg::entry_t  head,
  output logic             pop,
  rqd_byte_if.source       byte_stream
);

  logic [2:0] lvl_r;
  logic [2:0] lvl_g;
  logic [1:0] lvl_b;
  logic [7:0] packed_next;

  assign pop = head_valid && (!byte_stream.valid || byte_stream.ready);

  always_comb begin
    if (cfg.dither_enable) begin
      lvl_r = rqd_pkg::dith_rg(head.red, head.same_parity);
      lvl_g = rqd_pkg::dith_rg(head.green, head.same_parity);
      lvl_b = rqd_pkg::dith_b(head.blue, head.same_parity);
    end else begin
      lvl_r = rqd_pkg::plain_rg(head.red);
      lvl_g = rqd_pkg::plain_rg(head.green);
      lvl_b = rqd_pkg::plain_b(head.blue);
    end
    packed_next = head.transparent ? rqd_pkg::KEY_TRANSPARENT : {lvl_r, lvl_g, lvl_b};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_stream.valid <= 1'b0;
    end else if (pop) begin
      byte_stream.valid <= 1'b1;
    end else if (byte_stream.ready) begin
      byte_stream.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) byte_stream.packed_pixel <= packed_next;
  end

endmodule
`default_nettype wire

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: testbench for rgb332_quantize_checker_dither
// Streams RGBA pixels through the converter under several register settings
// and idle patterns. A local model of the quantizer and of the raster
// position tracker predicts every RGB332 byte, which is checked in order.
// ----------------------------------------------------------------------------
module tb;

  localparam int MAX_SHOWN = 10;

  typedef logic [rqd_pkg::PADDR_W-1:0] addr_t;
  typedef logic [rqd_pkg::PDATA_W-1:0] data_t;
  typedef logic [rqd_pkg::IMG_W-1:0]   width_t;

  logic  clk = 1'b0;
  logic  rst = 1'b1;
  logic  psel = 1'b0;
  logic  penable = 1'b0;
  logic  pwrite = 1'b0;
  addr_t paddr = '0;
  data_t pwdata = '0;
  data_t prdata;
  logic  pready;

  rqd_pixel_if pix_if ();
  rqd_byte_if  byte_if ();

  rgb332_quantize_checker_dither dut (
    .clk          (clk),
    .rst          (rst),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .pixel_stream (pix_if),
    .byte_stream  (byte_if)
  );

  // model of the converter
  logic                           cfg_dither = 1'b0;
  logic                           cfg_alpha = 1'b0;
  width_t                         cfg_width = rqd_pkg::IMAGE_WIDTH_RESET;
  logic [rqd_pkg::WIDTH_BITS-1:0] col_pos = '0;
  logic                           row_parity = 1'b0;

  logic [7:0] expected_bytes[$];
  logic [7:0] want_byte;
  int         error_count = 0;

  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  bit          hold_req = 1'b0;
  int          hold_len = 0;
  int          hold_left = 0;

  always #5 clk = ~clk;

  initial begin
    #3ms;
    $display("CHECK FAILED");
    $finish;
  end

  function automatic void flag_error(input string msg);
    if (error_count < MAX_SHOWN) $display("mismatch: %s", msg);
    error_count++;
  endfunction

  // round(c / 36.428) with the divisor held as 36428/1000
  function automatic int rounded_level(input logic [7:0] c);
    int lvl;
    lvl = (int'(c) * 1000 + 18214) / 36428;
    return (lvl > 7) ? 7 : lvl;
  endfunction

  // floor or ceiling of num/den at double resolution, then halved and capped
  function automatic int dither_level(input int num, input int den, input bit take_floor,
                                      input int cap);
    int q;
    q = num / den;
    if (!take_floor && (num % den) != 0) q++;
    q = q >> 1;
    return (q > cap) ? cap : q;
  endfunction

  function automatic logic [7:0] quantize_pixel(input logic [7:0] r, input logic [7:0] g,
                                                input logic [7:0] b, input logic [7:0] a,
                                                input logic fs);
    int         lr, lg, lb;
    bit         same;
    logic [7:0] px;
    if (fs) begin
      col_pos = '0;
      row_parity = 1'b0;
    end
    same = (col_pos[0] == row_parity);
    if (cfg_alpha && a != rqd_pkg::ALPHA_OPAQUE) begin
      px = rqd_pkg::KEY_TRANSPARENT;
    end else begin
      if (!cfg_dither) begin
        lr = rounded_level(r);
        lg = rounded_level(g);
        lb = int'(b) / 85;
      end else begin
        lr = dither_level(int'(r) * 1000, 18214, same, 7);
        lg = dither_level(int'(g) * 1000, 18214, same, 7);
        lb = dither_level(int'(b) * 2, 85, same, 3);
      end
      if (lb > 3) lb = 3;
      px = {3'(lr), 3'(lg), 2'(lb)};
    end
    // a width of zero behaves like one; a lowered width ends the row at once
    if (col_pos == '1 || 32'(col_pos) + 1 >= 32'(cfg_width)) begin
      col_pos = '0;
      row_parity = ~row_parity;
    end else begin
      col_pos = col_pos + 1'b1;
    end
    return px;
  endfunction

  // receiver side, including the long hold-off
  always @(posedge clk) begin
    if (hold_req) begin
      hold_left = hold_len;
      hold_req = 1'b0;
    end
    if (hold_left > 0) begin
      byte_if.ready <= 1'b0;
      hold_left--;
    end else begin
      byte_if.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst && byte_if.valid && byte_if.ready) begin
      if (expected_bytes.size() == 0) begin
        flag_error($sformatf("unexpected byte %02h", byte_if.packed_pixel));
      end else begin
        want_byte = expected_bytes.pop_front();
        if (byte_if.packed_pixel !== want_byte)
          flag_error($sformatf("packed_pixel expected %02h actual %02h",
                               want_byte, byte_if.packed_pixel));
      end
    end
  end

  task automatic send_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b,
                            input logic [7:0] a, input logic fs);
    while ($urandom_range(99) < send_idle_pct) begin
      pix_if.valid <= 1'b0;
      @(posedge clk);
    end
    pix_if.valid       <= 1'b1;
    pix_if.red         <= r;
    pix_if.green       <= g;
    pix_if.blue        <= b;
    pix_if.alpha       <= a;
    pix_if.frame_start <= fs;
    do @(posedge clk); while (!pix_if.ready);
    expected_bytes.push_back(quantize_pixel(r, g, b, a, fs));
  endtask

  task automatic drain_stream();
    pix_if.valid <= 1'b0;
    while (expected_bytes.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [rqd_pkg::REG_IDX_W-1:0] idx,
                           input data_t value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr_t'({idx, 2'b00});
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      rqd_pkg::REG_DITHER_ENABLE: cfg_dither = value[0];
      rqd_pkg::REG_ALPHA_PRESENT: cfg_alpha = value[0];
      rqd_pkg::REG_IMAGE_WIDTH:   cfg_width = value[rqd_pkg::IMG_W-1:0];
      default: ;
    endcase
  endtask

  task automatic set_config(input logic dith, input logic alpha_on, input width_t w);
    drain_stream();
    write_reg(rqd_pkg::REG_DITHER_ENABLE, data_t'(dith));
    write_reg(rqd_pkg::REG_ALPHA_PRESENT, data_t'(alpha_on));
    write_reg(rqd_pkg::REG_IMAGE_WIDTH, data_t'(w));
  endtask

  // values near the quantizer thresholds, channel extremes or uniform random values
  function automatic logic [7:0] pick_channel();
    int k;
    int v;
    case ($urandom_range(4))
      0: begin
        k = $urandom_range(14);
        v = (k * 18214) / 1000 + $urandom_range(2);
        return (v > 255) ? 8'd255 : 8'(v);
      end
      1: return 8'(85 * $urandom_range(3) + $urandom_range(2) - 1);
      2: return $urandom_range(1) ? 8'd255 : 8'd0;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  function automatic width_t pick_width();
    case ($urandom_range(5))
      0: return width_t'($urandom_range(1, 6));
      1: return width_t'($urandom_range(7, 40));
      2: return '0;
      3: return '1;
      4: return width_t'($urandom_range(65535));
      default: return width_t'($urandom_range(2, 12));
    endcase
  endfunction

  task automatic test_plain_rounding();
    send_pixel(8'd0, 8'd0, 8'd0, 8'd255, 1'b1);
    send_pixel(8'd255, 8'd255, 8'd255, 8'd0, 1'b0);
    send_pixel(8'd18, 8'd19, 8'd84, 8'd255, 1'b0);
    send_pixel(8'd54, 8'd55, 8'd85, 8'd255, 1'b0);
    send_pixel(8'd236, 8'd237, 8'd170, 8'd255, 1'b0);
    send_pixel(8'd127, 8'd128, 8'd254, 8'd255, 1'b0);
  endtask

  task automatic test_dither_cells();
    set_config(1'b1, 1'b0, 16'd3);
    send_pixel(8'd0, 8'd0, 8'd0, 8'd255, 1'b1);
    // same value across two rows of an odd width shows the checkerboard
    repeat (5) send_pixel(8'd100, 8'd150, 8'd200, 8'd255, 1'b0);
    send_pixel(8'd255, 8'd255, 8'd255, 8'd255, 1'b0);
    send_pixel(8'd36, 8'd37, 8'd85, 8'd255, 1'b0);
  endtask

  task automatic test_transparency();
    set_config(1'b0, 1'b1, 16'd4);
    send_pixel(8'd200, 8'd100, 8'd50, 8'd254, 1'b1);
    send_pixel(8'd200, 8'd100, 8'd50, 8'd255, 1'b0);
    send_pixel(8'd255, 8'd255, 8'd255, 8'd0, 1'b0);
    set_config(1'b1, 1'b1, 16'd4);
    send_pixel(8'd90, 8'd90, 8'd90, 8'd128, 1'b0);
  endtask

  task automatic test_width_limits();
    set_config(1'b1, 1'b0, 16'd1);
    repeat (2) send_pixel(8'd10, 8'd10, 8'd43, 8'd255, 1'b0);
    set_config(1'b1, 1'b0, 16'd0);
    repeat (2) send_pixel(8'd10, 8'd10, 8'd43, 8'd255, 1'b0);
    set_config(1'b1, 1'b0, 16'hFFFF);
    send_pixel(8'd10, 8'd10, 8'd43, 8'd255, 1'b1);
    send_pixel(8'd10, 8'd10, 8'd43, 8'd255, 1'b0);
    // lowering the width below the current column ends the row
    set_config(1'b1, 1'b0, 16'd8);
    send_pixel(8'd10, 8'd10, 8'd43, 8'd255, 1'b1);
    repeat (4) send_pixel(8'd10, 8'd10, 8'd43, 8'd255, 1'b0);
    set_config(1'b1, 1'b0, 16'd3);
    repeat (3) send_pixel(8'd10, 8'd10, 8'd43, 8'd255, 1'b0);
  endtask

  task automatic test_input_stall();
    set_config(1'b1, 1'b1, 16'd5);
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_len = 80;
    hold_req = 1'b1;
    repeat (30)
      send_pixel(pick_channel(), pick_channel(), pick_channel(),
                 $urandom_range(1) ? 8'd255 : 8'($urandom_range(255)), 1'b0);
  endtask

  task automatic run_segment(input int count);
    logic [7:0] a;
    set_config(($urandom_range(3) != 0), 1'($urandom_range(1)), pick_width());
    for (int i = 0; i < count; i++) begin
      a = $urandom_range(1) ? 8'd255 : 8'($urandom_range(255));
      send_pixel(pick_channel(), pick_channel(), pick_channel(), a,
                 (i == 0) || ($urandom_range(99) < 2));
    end
  endtask

  task automatic test_random_stream();
    send_idle_pct = 14;
    recv_stall_pct = 58;
    repeat (3) run_segment(100);
    send_idle_pct = 58;
    recv_stall_pct = 14;
    repeat (3) run_segment(100);
    send_idle_pct = 0;
    recv_stall_pct = 0;
    repeat (3) run_segment(100);
  endtask

  initial begin
    pix_if.valid       <= 1'b0;
    pix_if.red         <= '0;
    pix_if.green       <= '0;
    pix_if.blue        <= '0;
    pix_if.alpha       <= '0;
    pix_if.frame_start <= 1'b0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    test_plain_rounding();
    test_dither_cells();
    test_transparency();
    test_width_limits();
    test_input_stall();
    test_random_stream();

    drain_stream();
    repeat (10) @(posedge clk);
    if (expected_bytes.size() != 0)
      flag_error($sformatf("%0d bytes never arrived", expected_bytes.size()));
    if (error_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ===== rgb332_quantize_checker_dither.f =====
design/rqd_pkg.sv
design/rqd_pixel_if.sv
design/rqd_byte_if.sv
design/rqd_regs.sv
design/rqd_front.sv
design/rqd_queue.sv
design/rqd_back.sv
design/rgb332_quantize_checker_dither.sv
tb/tb.sv
